// File: rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and functions for the stuffed frame receiver
// Result record, configuration set, register indexes and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int unsigned MAX_BODY   = 32;
   localparam int unsigned COUNT_W    = 6;
   localparam logic [15:0] CRC_POLY   = 16'h1021;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_HEAD_CODE   = 2'd0,
      CSR_TAIL_CODE   = 2'd1,
      CSR_ESCAPE_CODE = 2'd2,
      CSR_CRC_INIT    = 2'd3
   } csr_index_type;

   localparam logic [7:0]  HEAD_CODE_RESET   = 8'hF4;
   localparam logic [7:0]  TAIL_CODE_RESET   = 8'h4F;
   localparam logic [7:0]  ESCAPE_CODE_RESET = 8'hFF;
   localparam logic [15:0] CRC_INIT_RESET    = 16'h0000;

   // second byte of an escape sequence
   localparam logic [7:0] ESC_SEL_HEAD   = 8'h01;
   localparam logic [7:0] ESC_SEL_ESCAPE = 8'h02;
   localparam logic [7:0] ESC_SEL_TAIL   = 8'h03;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [7:0]  head_code;
      logic [7:0]  tail_code;
      logic [7:0]  escape_code;
      logic [15:0] crc_init;
   } cfg_type;

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      data_byte;
      logic            crc_ok;
      logic            length_ok;
      logic            overflow;
      logic            last_of_input;
   } result_type;

   // body accumulation state
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [15:0]        crc;
      logic [7:0]         length_field;
      logic               overflowed;
      logic               took;
   } body_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   // one body byte: count it, capture the length byte, fold it into the CRC
   function automatic body_type body_step(input body_type s, input logic [7:0] b);
      body_type n;
      n = s;
      n.took = 1'b0;
      if (s.count >= COUNT_W'(MAX_BODY)) begin
         n.overflowed = 1'b1;
      end else begin
         if (s.count == COUNT_W'(2)) begin
            n.length_field = b;
         end
         n.crc   = crc_byte(s.crc, b);
         n.count = s.count + COUNT_W'(1);
         n.took  = 1'b1;
      end
      return n;
   endfunction

endpackage

// File: rtl/core/stuffed_frame_receiver_crc16.sv
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16: byte-stuffed frame receiver with CRC-16 check
// Removes head/tail/escape framing and reports CRC, length and overflow status.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one raw line byte per request (valid/ready).
//   rsp_*  : results in order; a data byte per body byte, a status at the tail.
//            last_of_input marks the final result of a request.
//   csr_*  : register writes (head, tail, escape, CRC init), always ready;
//            write only while the block is idle.
// Flow: an accepted request waits in the input register until the queue has
//   room for two results, then is decoded into it; its results follow on rsp.
// Throughput: one request per cycle while two queue entries are free. A request
//   makes zero, one or two results; the rsp port moves one per cycle, so runs
//   of escaped pairs that expand to two bytes are paced by the four-entry queue.
// Reset: registers return to their default codes, frame state is cleared
//   and the queue is emptied.
// Stall: when rsp_ready is low the queue fills; the decoder holds its
//   request once fewer than two entries are free and req_ready drops.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_crc_ok,
   output logic        rsp_length_ok,
   output logic        rsp_overflow,
   output logic        rsp_last_of_input,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import sfr_pkg::*;

   cfg_type    cfg_ff;
   logic       held_ff;
   logic [7:0] byte_ff;
   logic       fire;
   logic       room2;
   result_type res0, res1, out_res;
   logic [1:0] res_count;

   assign csr_ready = 1'b1;
   assign fire      = held_ff && room2;
   assign req_ready = !held_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_code   <= HEAD_CODE_RESET;
         cfg_ff.tail_code   <= TAIL_CODE_RESET;
         cfg_ff.escape_code <= ESCAPE_CODE_RESET;
         cfg_ff.crc_init    <= CRC_INIT_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_HEAD_CODE:   cfg_ff.head_code   <= csr_data[7:0];
            CSR_TAIL_CODE:   cfg_ff.tail_code   <= csr_data[7:0];
            CSR_ESCAPE_CODE: cfg_ff.escape_code <= csr_data[7:0];
            CSR_CRC_INIT:    cfg_ff.crc_init    <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else if (req_ready) begin
         held_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   sfr_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rx_byte   (byte_ff),
      .cfg       (cfg_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   sfr_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push0      (res0),
      .push1      (res1),
      .push_count (res_count),
      .room2      (room2),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_res)
   );

   assign rsp_result_kind   = out_res.kind;
   assign rsp_data_byte     = out_res.data_byte;
   assign rsp_crc_ok        = out_res.crc_ok;
   assign rsp_length_ok     = out_res.length_ok;
   assign rsp_overflow      = out_res.overflow;
   assign rsp_last_of_input = out_res.last_of_input;

endmodule

// File: rtl/core/sfr_deframer.sv
// ----------------------------------------------------------------------------
// sfr_deframer: frame state and byte decode
// Takes one raw byte per fire, updates frame state, emits up to two results.
// ----------------------------------------------------------------------------
module sfr_deframer (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          rx_byte,
   input  sfr_pkg::cfg_type    cfg,
   output sfr_pkg::result_type res0,
   output sfr_pkg::result_type res1,
   output logic [1:0]          res_count
);
   import sfr_pkg::*;

   logic     in_frame_ff, in_frame_in;
   logic     esc_pend_ff, esc_pend_in;
   body_type body_ff, body_in;

   body_type   body_base, body_a, body_b;
   logic       use_a, use_b;
   logic [7:0] byte_a, byte_b;
   result_type r0, r1;
   logic [1:0] n;

   always_comb begin
      in_frame_in = in_frame_ff;
      esc_pend_in = esc_pend_ff;
      body_base   = body_ff;
      body_base.took = 1'b0;
      use_a  = 1'b0;
      use_b  = 1'b0;
      byte_a = rx_byte;
      byte_b = rx_byte;
      r0 = '0;
      r1 = '0;
      n  = 2'd0;

      if (rx_byte == cfg.head_code) begin
         in_frame_in            = 1'b1;
         esc_pend_in            = 1'b0;
         body_base.overflowed   = 1'b0;
         body_base.crc          = cfg.crc_init;
         body_base.count        = '0;
         body_base.length_field = '0;
      end else if (in_frame_ff) begin
         if (rx_byte == cfg.tail_code) begin
            in_frame_in  = 1'b0;
            esc_pend_in  = 1'b0;
            r0.kind      = KIND_STATUS;
            r0.crc_ok    = (body_ff.crc == 16'h0000);
            r0.length_ok = ((body_ff.length_field - 8'd2) == {2'b00, body_ff.count});
            r0.overflow  = body_ff.overflowed;
            n            = 2'd1;
         end else if (esc_pend_ff) begin
            esc_pend_in = 1'b0;
            use_a       = 1'b1;
            case (rx_byte)
               ESC_SEL_HEAD:   byte_a = cfg.head_code;
               ESC_SEL_ESCAPE: byte_a = cfg.escape_code;
               ESC_SEL_TAIL:   byte_a = cfg.tail_code;
               default: begin
                  byte_a = cfg.escape_code;
                  use_b  = 1'b1;
               end
            endcase
         end else if (rx_byte == cfg.escape_code) begin
            esc_pend_in = 1'b1;
         end else begin
            use_a = 1'b1;
         end
      end

      body_a = use_a ? body_step(body_base, byte_a) : body_base;
      body_b = use_b ? body_step(body_a, byte_b) : body_a;
      body_in = body_b;

      if (body_a.took) begin
         r0.kind      = KIND_DATA;
         r0.data_byte = byte_a;
         n            = 2'd1;
         if (use_b && body_b.took) begin
            r1.kind      = KIND_DATA;
            r1.data_byte = byte_b;
            n            = 2'd2;
         end
      end

      // mark the final result of this byte
      if (n == 2'd2) begin
         r1.last_of_input = 1'b1;
      end else if (n == 2'd1) begin
         r0.last_of_input = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_pend_ff <= 1'b0;
         body_ff     <= '0;
      end else if (fire) begin
         in_frame_ff <= in_frame_in;
         esc_pend_ff <= esc_pend_in;
         body_ff     <= body_in;
      end
   end

   assign res0      = r0;
   assign res1      = r1;
   assign res_count = fire ? n : 2'd0;

endmodule

// File: rtl/core/sfr_out_queue.sv
// ----------------------------------------------------------------------------
// sfr_out_queue: result queue
// Takes up to two results per cycle, hands out one per rsp handshake.
// ----------------------------------------------------------------------------
module sfr_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  sfr_pkg::result_type push0,
   input  sfr_pkg::result_type push1,
   input  logic [1:0]          push_count,
   output logic                room2,
   output logic                out_valid,
   input  logic                out_ready,
   output sfr_pkg::result_type out_data
);
   import sfr_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pop;
   logic [PTR_W-1:0]   wr_next;

   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ff + PTR_W'(1);
   assign out_valid = (cnt_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign room2     = (cnt_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      wr_in  = wr_ff + PTR_W'(push_count);
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         slot_ff[wr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         slot_ff[wr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/core/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker: port-level checks for the stuffed frame receiver
// Watches the top level's channels and flags result records that break rules.
// ----------------------------------------------------------------------------
module sfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_kind,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_crc_ok,
   input logic       rsp_length_ok,
   input logic       rsp_overflow,
   input logic       rsp_last_of_input
);
   import sfr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before handshake");

   a_data_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_DATA)
         |-> !rsp_crc_ok && !rsp_length_ok && !rsp_overflow)
      else $error("data result carries status flags");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_STATUS)
         |-> rsp_last_of_input && (rsp_data_byte == 8'h00))
      else $error("status result not final or has data");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present right after reset");

endmodule

bind stuffed_frame_receiver_crc16 sfr_checker u_sfr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_crc_ok        (rsp_crc_ok),
   .rsp_length_ok     (rsp_length_ok),
   .rsp_overflow      (rsp_overflow),
   .rsp_last_of_input (rsp_last_of_input)
);

// File: tb/stuffed_frame_receiver_crc16_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc16_tb: self-checking bench for the frame receiver
// Sends stuffed frames, line noise and broken frames under random idle and
// stall. A bench-side deframer predicts each unstuffed byte and each tail
// status, and every response is compared field by field in order.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_crc16_tb;
   import sfr_pkg::*;

   localparam int RANDOM_ITEMS  = 700;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;

   // ways a generated frame can be broken
   localparam int FLAW_NONE         = 0;
   localparam int FLAW_BITFLIP      = 1;
   localparam int FLAW_LENGTH       = 2;
   localparam int FLAW_DANGLING_ESC = 3;
   localparam int FLAW_NO_TAIL      = 4;
   localparam int FLAW_COUNT        = 5;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_crc_ok;
   logic        rsp_length_ok;
   logic        rsp_overflow;
   logic        rsp_last_of_input;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   // deframer state as the bench sees it
   cfg_type            cfg_q;
   logic               in_frame_q;
   logic               esc_pending_q;
   logic               overflowed_q;
   logic [15:0]        crc_q;
   logic [COUNT_W-1:0] body_cnt_q;
   logic [7:0]         len_byte_q;
   result_type         frame_results_q[$];

   int req_gap_max   = 0;
   int rsp_stall_max = 0;
   int error_count   = 0;
   int items_sent    = 0;
   int frame_items   = 0;
   int cfg_sets      = 0;
   int data_seen     = 0;
   int status_seen   = 0;
   int crc_good_seen = 0;
   int overflow_seen = 0;

   stuffed_frame_receiver_crc16 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_crc_ok        (rsp_crc_ok),
      .rsp_length_ok     (rsp_length_ok),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_of_input (rsp_last_of_input),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #2 clock = ~clock;

   task automatic flag_error(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   // bit-serial CRC-16, MSB first
   function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         if (r[15] ^ b[i]) begin
            r = (r << 1) ^ CRC_POLY;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

   function automatic void push_result(input result_kind_type kind, input logic [7:0] data,
                                       input logic cok, input logic lok, input logic ovf);
      result_type r;
      r.kind          = kind;
      r.data_byte     = data;
      r.crc_ok        = cok;
      r.length_ok     = lok;
      r.overflow      = ovf;
      r.last_of_input = 1'b0;
      frame_results_q.push_back(r);
   endfunction

   function automatic void take_body_byte(input logic [7:0] b);
      if (int'(body_cnt_q) >= MAX_BODY) begin
         // drop the excess byte, remember the overrun
         overflowed_q = 1'b1;
      end else begin
         if (body_cnt_q == COUNT_W'(2)) begin
            len_byte_q = b;
         end
         crc_q      = crc16_next(crc_q, b);
         body_cnt_q = body_cnt_q + 1'b1;
         push_result(KIND_DATA, b, 1'b0, 1'b0, 1'b0);
      end
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      int         n_prior;
      result_type r;
      logic [7:0] len_less2;
      n_prior = frame_results_q.size();
      if (b == cfg_q.head_code) begin
         in_frame_q    = 1'b1;
         esc_pending_q = 1'b0;
         overflowed_q  = 1'b0;
         crc_q         = cfg_q.crc_init;
         body_cnt_q    = '0;
         len_byte_q    = '0;
      end else if (in_frame_q) begin
         if (b == cfg_q.tail_code) begin
            len_less2 = len_byte_q - 8'd2;
            push_result(KIND_STATUS, 8'h00, crc_q == 16'h0000,
                        len_less2 == 8'(body_cnt_q), overflowed_q);
            in_frame_q    = 1'b0;
            esc_pending_q = 1'b0;
         end else if (esc_pending_q) begin
            esc_pending_q = 1'b0;
            case (b)
               ESC_SEL_HEAD: begin
                  take_body_byte(cfg_q.head_code);
               end
               ESC_SEL_ESCAPE: begin
                  take_body_byte(cfg_q.escape_code);
               end
               ESC_SEL_TAIL: begin
                  take_body_byte(cfg_q.tail_code);
               end
               default: begin
                  take_body_byte(cfg_q.escape_code);
                  take_body_byte(b);
               end
            endcase
         end else if (b == cfg_q.escape_code) begin
            esc_pending_q = 1'b1;
         end else begin
            take_body_byte(b);
         end
      end
      if (frame_results_q.size() > n_prior) begin
         r = frame_results_q[frame_results_q.size() - 1];
         r.last_of_input = 1'b1;
         frame_results_q[frame_results_q.size() - 1] = r;
      end
   endfunction

   // random byte with a bias toward the framing codes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 11))
         0: return cfg_q.head_code;
         1: return cfg_q.tail_code;
         2, 3: return cfg_q.escape_code;
         4: return ESC_SEL_HEAD;
         5: return ESC_SEL_ESCAPE;
         6: return ESC_SEL_TAIL;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void set_pace();
      req_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 7;
      rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
   endfunction

   task automatic send_req(input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      deframe_byte(b);
      items_sent++;
   endtask

   // hold requests until every predicted result is back and the decoder is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (frame_results_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic write_cfg(input cfg_type c);
      settle();
      csr_write(CSR_HEAD_CODE, {8'h00, c.head_code});
      csr_write(CSR_TAIL_CODE, {8'h00, c.tail_code});
      csr_write(CSR_ESCAPE_CODE, {8'h00, c.escape_code});
      csr_write(CSR_CRC_INIT, c.crc_init);
      csr_valid <= 1'b0;
      cfg_q = c;
      cfg_sets++;
   endtask

   // build a body (length byte, trailing CRC if five bytes up), stuff it, send it
   task automatic send_frame(input int body_len, input int flaw);
      logic [7:0]  body[$];
      logic [7:0]  raw[$];
      logic [15:0] c;
      logic [7:0]  v;
      logic [7:0]  nxt;
      int          i;
      for (i = 0; i < body_len; i++) begin
         body.push_back(pick_byte());
      end
      if (body_len >= 5) begin
         body[2] = 8'(body_len + 2);
         if (flaw == FLAW_LENGTH) begin
            body[2] = body[2] + 8'd1;
         end
         c = cfg_q.crc_init;
         for (i = 0; i < body_len - 2; i++) begin
            c = crc16_next(c, body[i]);
         end
         body[body_len - 2] = c[15:8];
         body[body_len - 1] = c[7:0];
      end
      if (flaw == FLAW_BITFLIP && body_len > 0) begin
         i = $urandom_range(0, body_len - 1);
         body[i] = body[i] ^ (8'h01 << $urandom_range(0, 7));
      end
      raw.push_back(cfg_q.head_code);
      i = 0;
      while (i < body_len) begin
         v   = body[i];
         nxt = (i + 1 < body_len) ? body[i + 1] : 8'h00;
         if (v == cfg_q.head_code) begin
            raw.push_back(cfg_q.escape_code);
            raw.push_back(ESC_SEL_HEAD);
         end else if (v == cfg_q.tail_code) begin
            raw.push_back(cfg_q.escape_code);
            raw.push_back(ESC_SEL_TAIL);
         end else if (v == cfg_q.escape_code) begin
            raw.push_back(cfg_q.escape_code);
            // an escape followed by a plain byte may travel as the raw pair
            if (i + 1 < body_len && nxt != ESC_SEL_HEAD && nxt != ESC_SEL_ESCAPE &&
                nxt != ESC_SEL_TAIL && nxt != cfg_q.head_code &&
                nxt != cfg_q.tail_code && $urandom_range(0, 1) == 1) begin
               raw.push_back(nxt);
               i++;
            end else begin
               raw.push_back(ESC_SEL_ESCAPE);
            end
         end else begin
            raw.push_back(v);
         end
         i++;
      end
      if (flaw == FLAW_DANGLING_ESC) begin
         raw.push_back(cfg_q.escape_code);
      end
      if (flaw != FLAW_NO_TAIL) begin
         raw.push_back(cfg_q.tail_code);
      end
      foreach (raw[k]) begin
         send_req(raw[k]);
      end
      frame_items += raw.size();
   endtask

   task automatic run_frames(input int n_items);
      int goal;
      int body_len;
      int flaw;
      goal = frame_items + n_items;
      while (frame_items < goal) begin
         for (int k = $urandom_range(0, 2); k > 0; k--) begin
            send_req(pick_byte());
         end
         case ($urandom_range(0, 7))
            0: body_len = $urandom_range(0, 4);
            1: body_len = $urandom_range(MAX_BODY - 2, MAX_BODY + 6);
            default: body_len = $urandom_range(5, 16);
         endcase
         flaw = ($urandom_range(0, 1) == 1) ? FLAW_NONE : $urandom_range(1, FLAW_COUNT - 1);
         send_frame(body_len, flaw);
      end
   endtask

   // escape forms, reopen, dangling escape, empty frame and noise at reset codes
   task automatic test_stuffing_rules();
      logic [7:0] seq[$];
      set_pace();
      seq = '{TAIL_CODE_RESET, ESCAPE_CODE_RESET, 8'h00,
              HEAD_CODE_RESET, 8'h00,
              ESCAPE_CODE_RESET, ESC_SEL_HEAD,
              ESCAPE_CODE_RESET, ESC_SEL_ESCAPE,
              ESCAPE_CODE_RESET, ESC_SEL_TAIL,
              ESCAPE_CODE_RESET, 8'h55,
              ESCAPE_CODE_RESET, HEAD_CODE_RESET,
              8'h12, ESCAPE_CODE_RESET, TAIL_CODE_RESET,
              HEAD_CODE_RESET, TAIL_CODE_RESET, 8'hAA};
      foreach (seq[k]) begin
         send_req(seq[k]);
      end
      settle();
   endtask

   task automatic test_code_extremes();
      set_pace();
      write_cfg('{8'h00, 8'hFF, 8'h80, 16'hFFFF});
      run_frames(80);
      set_pace();
      write_cfg('{8'hFF, 8'h00, ESC_SEL_HEAD, 16'h0000});
      run_frames(80);
   endtask

   // overlapping codes: the head wins over all, the tail over the escape
   task automatic test_code_collisions();
      set_pace();
      write_cfg('{ESC_SEL_TAIL, ESC_SEL_ESCAPE, ESC_SEL_ESCAPE, 16'($urandom)});
      run_frames(40);
      write_cfg('{8'h10, 8'h10, 8'h11, 16'($urandom)});
      run_frames(40);
      write_cfg('{8'h20, 8'h21, 8'h20, 16'($urandom)});
      run_frames(40);
   endtask

   task automatic test_random_frames();
      cfg_type c;
      while (frame_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            c = '{HEAD_CODE_RESET, TAIL_CODE_RESET, ESCAPE_CODE_RESET, CRC_INIT_RESET};
         end else begin
            c.head_code = 8'($urandom);
            do c.tail_code = 8'($urandom); while (c.tail_code == c.head_code);
            do c.escape_code = 8'($urandom);
            while (c.escape_code == c.head_code || c.escape_code == c.tail_code);
            c.crc_init = 16'($urandom);
         end
         set_pace();
         write_cfg(c);
         run_frames(100);
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         flag_error($sformatf("%s got %02h want %02h", name, got, want));
      end
   endtask

   initial begin : rsp_check
      int         stall;
      result_type want;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (frame_results_q.size() == 0) begin
            flag_error($sformatf("unpredicted response kind %0b data %02h",
                                 rsp_result_kind, rsp_data_byte));
         end else begin
            want = frame_results_q.pop_front();
            compare_field("result_kind", 8'(rsp_result_kind), 8'(want.kind));
            compare_field("data_byte", rsp_data_byte, want.data_byte);
            compare_field("crc_ok", 8'(rsp_crc_ok), 8'(want.crc_ok));
            compare_field("length_ok", 8'(rsp_length_ok), 8'(want.length_ok));
            compare_field("overflow", 8'(rsp_overflow), 8'(want.overflow));
            compare_field("last_of_input", 8'(rsp_last_of_input), 8'(want.last_of_input));
            if (want.kind == KIND_STATUS) begin
               status_seen++;
               if (want.crc_ok) begin
                  crc_good_seen++;
               end
               if (want.overflow) begin
                  overflow_seen++;
               end
            end else begin
               data_seen++;
            end
         end
      end
   end

   initial begin
      int guard;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_HEAD_CODE;
      csr_data    <= 16'h0000;
      cfg_q         = '{HEAD_CODE_RESET, TAIL_CODE_RESET, ESCAPE_CODE_RESET, CRC_INIT_RESET};
      in_frame_q    = 1'b0;
      esc_pending_q = 1'b0;
      overflowed_q  = 1'b0;
      crc_q         = '0;
      body_cnt_q    = '0;
      len_byte_q    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_stuffing_rules();
      test_code_extremes();
      test_code_collisions();
      test_random_frames();

      req_valid <= 1'b0;
      guard = 0;
      while (frame_results_q.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (frame_results_q.size() != 0) begin
         flag_error($sformatf("%0d predicted results never came", frame_results_q.size()));
      end

      $display("run: %0d request bytes, %0d inside generated frames, %0d code settings",
               items_sent, frame_items, cfg_sets);
      $display("run: %0d data bytes and %0d statuses checked, %0d crc good, %0d overrun",
               data_seen, status_seen, crc_good_seen, overflow_seen);
      if (error_count == 0) begin
         $display("stuffed_frame_receiver_crc16_tb passed");
      end else begin
         $display("stuffed_frame_receiver_crc16_tb failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("ERROR: run did not complete in time");
      $display("stuffed_frame_receiver_crc16_tb failed");
      $finish;
   end

endmodule
